FILE: rtl/pss_pkg.sv
// ----------------------------------------------------------------------------
// pss_pkg: shared types and codes of the positional sequence store
// Request and result payloads, request and status codes, cell control.
// ----------------------------------------------------------------------------
package pss_pkg;

    localparam int DATA_W     = 16;
    localparam int GROUP_SIZE = 32;

    localparam logic [2:0] MODE_READ   = 3'd0;
    localparam logic [2:0] MODE_HEAD   = 3'd1;
    localparam logic [2:0] MODE_TAIL   = 3'd2;
    localparam logic [2:0] MODE_BEFORE = 3'd3;
    localparam logic [2:0] MODE_DELETE = 3'd4;

    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_IGNORED = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    typedef struct packed {
        logic [2:0]        mode;
        logic signed [7:0] position;
        logic [15:0]       value;
    } req_t;

    typedef struct packed {
        logic signed [16:0] read_data;
        logic [1:0]         status;
        logic [6:0]         length;
    } rsp_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_DELETE
    } shift_op_t;

    typedef struct packed {
        shift_op_t         op;
        logic              rd;
        logic [DATA_W-1:0] value;
    } cell_ctrl_t;

    typedef enum logic {
        ST_IDLE,
        ST_REDUCE
    } state_t;

endpackage

FILE: rtl/pss_cell.sv
// ----------------------------------------------------------------------------
// pss_cell: one entry of the sequence
// Holds one value; shifts up, shifts down or loads on insert and delete,
// and drives its value onto the read lines when addressed.
// ----------------------------------------------------------------------------
module pss_cell #(
    parameter int IDX = 0,
    parameter int IW  = 6
) (
    input  logic                        aclk,
    input  pss_pkg::cell_ctrl_t         ctrl,
    input  logic [IW-1:0]               slot,
    input  logic [pss_pkg::DATA_W-1:0]  left_data,
    input  logic [pss_pkg::DATA_W-1:0]  right_data,
    output logic [pss_pkg::DATA_W-1:0]  data,
    output logic [pss_pkg::DATA_W-1:0]  rd_data
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic [pss_pkg::DATA_W-1:0] data_reg;
    logic [pss_pkg::DATA_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        case (ctrl.op)
            pss_pkg::OP_INSERT: begin
                if (MY_IDX > slot) begin
                    data_next = left_data;
                end else if (MY_IDX == slot) begin
                    data_next = ctrl.value;
                end
            end
            pss_pkg::OP_DELETE: begin
                // pull the right neighbor in to close the gap
                if (MY_IDX >= slot) begin
                    data_next = right_data;
                end
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_data = (ctrl.rd && (MY_IDX == slot)) ? data_reg : '0;

endmodule

FILE: rtl/pss_group.sv
// ----------------------------------------------------------------------------
// pss_group: registered read collector for one group of cells
// ORs the masked read lines of up to GROUP_SIZE cells into a register.
// ----------------------------------------------------------------------------
module pss_group #(
    parameter int N = 32
) (
    input  logic                          aclk,
    input  logic                          load,
    input  logic [N*pss_pkg::DATA_W-1:0]  words,
    output logic [pss_pkg::DATA_W-1:0]    q
);

    logic [pss_pkg::DATA_W-1:0] acc_reg;
    logic [pss_pkg::DATA_W-1:0] acc_next;

    always_comb begin
        acc_next = '0;
        for (int i = 0; i < N; i++) begin
            acc_next = acc_next | words[i*pss_pkg::DATA_W +: pss_pkg::DATA_W];
        end
    end

    // hold the collected word until the next request is taken
    always_ff @(posedge aclk) begin
        if (load) begin
            acc_reg <= acc_next;
        end
    end

    assign q = acc_reg;

endmodule

FILE: rtl/positional_sequence_store_unit.sv
// ----------------------------------------------------------------------------
// positional_sequence_store_unit: ordered store addressed by position
// Keeps up to CAPACITY 16-bit values in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ channel (valid/ready); each transfer carries a
//   mode, a signed position and a value. Every request gives one result on
//   the m_ channel: read data (-1 when none), a status and the new length.
//   Inserts and deletes move every later entry by one cell in the cycle the
//   request transfers; each cell compares its own index with the slot.
//   A read is collected in two registered OR levels: groups of 32 cells,
//   then the group words.
//   A transferred request loads the group registers and enters the collect
//   state, which writes the result into the output register. The input is
//   held off during the collect step that follows each transfer.
//   The result sits in an output register. When the receiver stalls, the
//   block still takes one new request and applies it to the store, then
//   holds its result until the output register frees up.
//   Reset clears the entry count and the handshake state; no clearing pass
//   runs, because only positions below the count are ever read.
// ----------------------------------------------------------------------------
module positional_sequence_store_unit #(
    parameter int CAPACITY = 64
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  pss_pkg::req_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output pss_pkg::rsp_t   m_data
);

    localparam int DW = pss_pkg::DATA_W;
    localparam int GS = pss_pkg::GROUP_SIZE;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int LW = (CW > 7) ? CW : 7;
    localparam int NG = (CAPACITY + GS - 1) / GS;

    pss_pkg::state_t     state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [1:0]          status_reg, status_next;
    logic                hit_reg, hit_next;
    logic                m_valid_reg, m_valid_next;
    pss_pkg::rsp_t       m_data_reg, m_data_next;

    pss_pkg::cell_ctrl_t ctrl;
    logic [IW-1:0]       slot;
    logic                accept;
    logic                full;
    logic                pos_neg;
    logic [LW-1:0]       cnt_w;
    logic [LW-1:0]       pos_w;
    logic [DW-1:0]       read_word;

    logic [DW-1:0]       cell_q [CAPACITY];
    logic [CAPACITY*DW-1:0] rd_flat;
    logic [NG*DW-1:0]    grp_flat;

    assign s_ready = (state_reg == pss_pkg::ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign full    = (count_reg == CW'(CAPACITY));
    assign pos_neg = s_data.position[7];
    assign cnt_w   = LW'(count_reg);
    assign pos_w   = LW'(s_data.position[6:0]);

    // Decode the request against the current count and drive the cells.
    always_comb begin
        ctrl.op     = pss_pkg::OP_HOLD;
        ctrl.rd     = 1'b0;
        ctrl.value  = s_data.value;
        slot        = IW'(s_data.position[6:0]);
        status_next = pss_pkg::STATUS_IGNORED;
        hit_next    = 1'b0;
        count_next  = count_reg;
        case (s_data.mode)
            pss_pkg::MODE_READ: begin
                if (!pos_neg && (pos_w < cnt_w)) begin
                    ctrl.rd     = 1'b1;
                    hit_next    = 1'b1;
                    status_next = pss_pkg::STATUS_DONE;
                end
            end
            pss_pkg::MODE_HEAD: begin
                slot = '0;
                if (full) begin
                    status_next = pss_pkg::STATUS_FULL;
                end else begin
                    ctrl.op     = pss_pkg::OP_INSERT;
                    status_next = pss_pkg::STATUS_DONE;
                    count_next  = count_reg + CW'(1);
                end
            end
            pss_pkg::MODE_TAIL: begin
                slot = IW'(count_reg);
                if (full) begin
                    status_next = pss_pkg::STATUS_FULL;
                end else begin
                    ctrl.op     = pss_pkg::OP_INSERT;
                    status_next = pss_pkg::STATUS_DONE;
                    count_next  = count_reg + CW'(1);
                end
            end
            pss_pkg::MODE_BEFORE: begin
                // negative position goes to the head; past the count is ignored
                if (pos_neg) begin
                    slot = '0;
                end
                if (!pos_neg && (pos_w > cnt_w)) begin
                    status_next = pss_pkg::STATUS_IGNORED;
                end else if (full) begin
                    status_next = pss_pkg::STATUS_FULL;
                end else begin
                    ctrl.op     = pss_pkg::OP_INSERT;
                    status_next = pss_pkg::STATUS_DONE;
                    count_next  = count_reg + CW'(1);
                end
            end
            pss_pkg::MODE_DELETE: begin
                if (!pos_neg && (pos_w < cnt_w)) begin
                    ctrl.op     = pss_pkg::OP_DELETE;
                    status_next = pss_pkg::STATUS_DONE;
                    count_next  = count_reg - CW'(1);
                end
            end
            default: begin
                status_next = pss_pkg::STATUS_IGNORED;
            end
        endcase
        // only a transfer may move the cells
        if (!accept) begin
            ctrl.op    = pss_pkg::OP_HOLD;
            ctrl.rd    = 1'b0;
            count_next = count_reg;
        end
    end

    // Row of cells: each sees its neighbors, with zero past either end of the row.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DW-1:0] left_d;
        logic [DW-1:0] right_d;
        if (i == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_mid_l
            assign left_d = cell_q[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_d = '0;
        end else begin : g_mid_r
            assign right_d = cell_q[i+1];
        end
        pss_cell #(
            .IDX (i),
            .IW  (IW)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .slot       (slot),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_q[i]),
            .rd_data    (rd_flat[i*DW +: DW])
        );
    end

    // First read level: one registered OR per group of cells.
    for (genvar g = 0; g < NG; g++) begin : g_grp
        localparam int GN = (CAPACITY - g*GS > GS) ? GS : (CAPACITY - g*GS);
        pss_group #(
            .N (GN)
        ) u_group (
            .aclk  (aclk),
            .load  (accept),
            .words (rd_flat[g*GS*DW +: GN*DW]),
            .q     (grp_flat[g*DW +: DW])
        );
    end

    // Second read level: OR the group words.
    always_comb begin
        read_word = '0;
        for (int g = 0; g < NG; g++) begin
            read_word = read_word | grp_flat[g*DW +: DW];
        end
    end

    // Sequencer and output register.
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            pss_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = pss_pkg::ST_REDUCE;
                end
            end
            pss_pkg::ST_REDUCE: begin
                // wait here while the previous result is still unclaimed
                if (!m_valid_reg || m_ready) begin
                    m_valid_next          = 1'b1;
                    m_data_next.read_data = hit_reg ? $signed({1'b0, read_word})
                                                    : '1;
                    m_data_next.status    = status_reg;
                    m_data_next.length    = cnt_w[6:0];
                    state_next            = pss_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pss_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pss_pkg::ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (accept) begin
            status_reg <= status_next;
            hit_reg    <= hit_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // The count moves only right after a transfer.
    a_count_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |-> $past(accept))
        else $error("entry count changed without a request");

    // A result appears only out of the collect step.
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == pss_pkg::ST_REDUCE))
        else $error("result raised outside the collect step");

    // A full status always comes with a full store.
    a_full_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pss_pkg::ST_REDUCE && status_reg == pss_pkg::STATUS_FULL)
        |-> full)
        else $error("full status with room left");

endmodule

FILE: test/positional_sequence_store_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_sequence_store_unit_tb: self-checking bench for the sequence store
// Drives read, insert and delete requests through the valid/ready channels.
// A shadow list predicts each result. Checks cover a directed probe table,
// then random grow, mixed and shrink phases with random stalls on both sides.
// ----------------------------------------------------------------------------
module positional_sequence_store_unit_tb;

    localparam int CAPACITY         = 64;
    localparam int RANDOM_ITEMS     = 1025;
    localparam int QUIET_TAIL       = 150;
    localparam int LONG_HOLD_AT     = 300;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int DRAIN_CYCLES     = 8;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int REPORT_LIMIT     = 10;

    localparam logic signed [16:0] NO_READ_DATA = -17'sd1;

    typedef enum int {
        PH_GROW,
        PH_MIXED,
        PH_SHRINK
    } phase_t;

    // One row of the directed table: the request, and a typed-in result
    // where fixed is set (otherwise the shadow list gives the result).
    typedef struct packed {
        pss_pkg::req_t req;
        logic          fixed;
        pss_pkg::rsp_t rsp;
    } probe_t;

    logic          aclk;
    logic          aresetn;
    logic          s_valid;
    logic          s_ready;
    pss_pkg::req_t s_data;
    logic          m_valid;
    logic          m_ready;
    pss_pkg::rsp_t m_data;

    // Shadow of the store contents, head first, and results still owed.
    logic [15:0]   shadow_entries[$];
    pss_pkg::rsp_t pending_results[$];

    int  mismatch_count = 0;
    int  results_seen   = 0;
    int  sent_count     = 0;
    bit  quiet          = 1'b0;
    bit  sender_gaps    = 1'b1;

    positional_sequence_store_unit #(
        .CAPACITY(CAPACITY)
    ) uut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Apply one request to the shadow list and return the result it owes.
    // The past-count check on insert-before comes ahead of the full check:
    // slot stays negative for an ignored request, so no full check runs.
    function automatic pss_pkg::rsp_t apply_request(pss_pkg::req_t req);
        pss_pkg::rsp_t rsp;
        int            pos;
        int            slot;
        int            count;
        pos           = $signed(req.position);
        slot          = -1;
        count         = shadow_entries.size();
        rsp.read_data = NO_READ_DATA;
        rsp.status    = pss_pkg::STATUS_DONE;
        case (req.mode)
            pss_pkg::MODE_READ: begin
                if (pos >= 0 && pos < count) begin
                    rsp.read_data = {1'b0, shadow_entries[pos]};
                end else begin
                    rsp.status = pss_pkg::STATUS_IGNORED;
                end
            end
            pss_pkg::MODE_HEAD: slot = 0;
            pss_pkg::MODE_TAIL: slot = count;
            pss_pkg::MODE_BEFORE: begin
                // Negative position lands at the head, count appends.
                if (pos < 0) begin
                    slot = 0;
                end else if (pos > count) begin
                    rsp.status = pss_pkg::STATUS_IGNORED;
                end else begin
                    slot = pos;
                end
            end
            pss_pkg::MODE_DELETE: begin
                if (pos >= 0 && pos < count) begin
                    shadow_entries.delete(pos);
                end else begin
                    rsp.status = pss_pkg::STATUS_IGNORED;
                end
            end
            default: rsp.status = pss_pkg::STATUS_IGNORED;
        endcase
        if (slot >= 0) begin
            if (count >= CAPACITY) begin
                rsp.status = pss_pkg::STATUS_FULL;
            end else begin
                shadow_entries.insert(slot, req.value);
            end
        end
        count      = shadow_entries.size();
        rsp.length = count[6:0];
        return rsp;
    endfunction

    // Build a directed row; fixed rows never read, so their data is -1.
    function automatic probe_t make_probe(logic [2:0] mode, int pos, int value,
                                          bit fixed, logic [1:0] status,
                                          int length);
        probe_t p;
        p.req.mode      = mode;
        p.req.position  = pos[7:0];
        p.req.value     = value[15:0];
        p.fixed         = fixed;
        p.rsp.read_data = NO_READ_DATA;
        p.rsp.status    = status;
        p.rsp.length    = length[6:0];
        return p;
    endfunction

    // Draw a request shaped by the phase: grow favors inserts, shrink
    // favors deletes. Most positions sit near the valid range, the rest
    // span the whole signed byte.
    function automatic pss_pkg::req_t random_request(phase_t kind);
        pss_pkg::req_t req;
        int            count;
        int            ins_w;
        int            del_w;
        int            roll;
        int            pick;
        int            pos;
        int            value;
        count = shadow_entries.size();
        case (kind)
            PH_GROW: begin
                ins_w = 75;
                del_w = 8;
            end
            PH_MIXED: begin
                ins_w = 40;
                del_w = 30;
            end
            default: begin
                ins_w = 15;
                del_w = 55;
            end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < ins_w) begin
            case ($urandom_range(0, 2))
                0: req.mode = pss_pkg::MODE_HEAD;
                1: req.mode = pss_pkg::MODE_TAIL;
                default: req.mode = pss_pkg::MODE_BEFORE;
            endcase
        end else if (roll < ins_w + del_w) begin
            req.mode = pss_pkg::MODE_DELETE;
        end else if (roll < 96) begin
            req.mode = pss_pkg::MODE_READ;
        end else begin
            // Undefined codes 5 to 7.
            pick     = $urandom_range(5, 7);
            req.mode = pick[2:0];
        end
        if ($urandom_range(0, 4) == 0) begin
            pos = $urandom_range(0, 255) - 128;
        end else begin
            pos = $urandom_range(0, count + 3) - 2;
        end
        case ($urandom_range(0, 9))
            0: value = 0;
            1: value = 16'hFFFF;
            default: value = $urandom;
        endcase
        req.position = pos[7:0];
        req.value    = value[15:0];
        return req;
    endfunction

    // Offer one transfer and hold it until accepted. Valid stays high
    // into the next offer, so a gap lowers it only on its own edge.
    task automatic offer_request(input pss_pkg::req_t req, input bit fixed,
                                 input pss_pkg::rsp_t fixed_rsp);
        pss_pkg::rsp_t predicted;
        if (sender_gaps && !quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        predicted = apply_request(req);
        pending_results.push_back(fixed ? fixed_rsp : predicted);
        sent_count++;
    endtask

    // Lower valid and wait until every owed result has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic report_mismatch(input string what, input pss_pkg::rsp_t want,
                                   input pss_pkg::rsp_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $write("[%0t] %s: expected data=%0d status=%0d length=%0d",
                   $realtime, what, want.read_data, want.status, want.length);
            $display(", got data=%0d status=%0d length=%0d",
                     got.read_data, got.status, got.length);
        end
    endtask

    // Compare each result transfer with the oldest owed result.
    always @(posedge aclk) begin : result_check
        pss_pkg::rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing owed", '0, m_data);
            end else begin
                want = pending_results.pop_front();
                if (m_data.read_data !== want.read_data || m_data.status !== want.status
                    || m_data.length !== want.length) begin
                    report_mismatch("result mismatch", want, m_data);
                end
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off that lets the
    // block fill its output register and push back on the input.
    initial begin : result_sink
        int stall_len;
        int held_cycles;
        bit long_hold_done;
        long_hold_done = 1'b0;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        m_ready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
                long_hold_done = 1'b1;
                held_cycles    = 0;
                m_ready <= 1'b0;
                while (held_cycles < LONG_HOLD_CYCLES) begin
                    @(posedge aclk);
                    held_cycles++;
                end
                m_ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                stall_len = $urandom_range(1, 9);
                m_ready <= 1'b0;
                repeat (stall_len) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    // Abort a hung run.
    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        probe_t probes[$];
        phase_t kind;
        int     phase_idx;
        int     phase_len;
        int     n;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table: empty store, value extremes, every mode,
        // out-of-range reads and deletes, negative and past-count
        // insert-before, undefined mode codes.
        probes.push_back(make_probe(pss_pkg::MODE_READ, 0, 0, 1,
                                    pss_pkg::STATUS_IGNORED, 0));
        probes.push_back(make_probe(pss_pkg::MODE_DELETE, 0, 0, 1,
                                    pss_pkg::STATUS_IGNORED, 0));
        probes.push_back(make_probe(pss_pkg::MODE_BEFORE, 1, 16'h1111, 1,
                                    pss_pkg::STATUS_IGNORED, 0));
        probes.push_back(make_probe(pss_pkg::MODE_HEAD, 0, 16'h0000, 1,
                                    pss_pkg::STATUS_DONE, 1));
        probes.push_back(make_probe(pss_pkg::MODE_TAIL, 0, 16'hFFFF, 1,
                                    pss_pkg::STATUS_DONE, 2));
        probes.push_back(make_probe(pss_pkg::MODE_BEFORE, -128, 16'hAAAA, 1,
                                    pss_pkg::STATUS_DONE, 3));
        probes.push_back(make_probe(pss_pkg::MODE_BEFORE, 3, 16'h5555, 1,
                                    pss_pkg::STATUS_DONE, 4));
        probes.push_back(make_probe(pss_pkg::MODE_BEFORE, 5, 16'h1234, 1,
                                    pss_pkg::STATUS_IGNORED, 4));
        probes.push_back(make_probe(pss_pkg::MODE_READ, 0, 0, 0,
                                    pss_pkg::STATUS_DONE, 0));
        probes.push_back(make_probe(pss_pkg::MODE_READ, 3, 0, 0,
                                    pss_pkg::STATUS_DONE, 0));
        probes.push_back(make_probe(pss_pkg::MODE_READ, 2, 0, 0,
                                    pss_pkg::STATUS_DONE, 0));
        probes.push_back(make_probe(pss_pkg::MODE_READ, 4, 0, 1,
                                    pss_pkg::STATUS_IGNORED, 4));
        probes.push_back(make_probe(pss_pkg::MODE_READ, -1, 0, 1,
                                    pss_pkg::STATUS_IGNORED, 4));
        probes.push_back(make_probe(pss_pkg::MODE_READ, -128, 0, 1,
                                    pss_pkg::STATUS_IGNORED, 4));
        probes.push_back(make_probe(pss_pkg::MODE_READ, 127, 0, 1,
                                    pss_pkg::STATUS_IGNORED, 4));
        probes.push_back(make_probe(pss_pkg::MODE_DELETE, -1, 0, 1,
                                    pss_pkg::STATUS_IGNORED, 4));
        probes.push_back(make_probe(pss_pkg::MODE_DELETE, 4, 0, 1,
                                    pss_pkg::STATUS_IGNORED, 4));
        probes.push_back(make_probe(pss_pkg::MODE_DELETE, 1, 0, 0,
                                    pss_pkg::STATUS_DONE, 0));
        probes.push_back(make_probe(3'd5, 0, 0, 1,
                                    pss_pkg::STATUS_IGNORED, 3));
        probes.push_back(make_probe(3'd7, 127, 16'hFFFF, 1,
                                    pss_pkg::STATUS_IGNORED, 3));
        probes.push_back(make_probe(pss_pkg::MODE_BEFORE, 1, 16'h1234, 0,
                                    pss_pkg::STATUS_DONE, 0));
        probes.push_back(make_probe(pss_pkg::MODE_READ, 1, 0, 0,
                                    pss_pkg::STATUS_DONE, 0));
        probes.push_back(make_probe(pss_pkg::MODE_DELETE, 0, 0, 0,
                                    pss_pkg::STATUS_DONE, 0));
        probes.push_back(make_probe(pss_pkg::MODE_READ, 0, 0, 0,
                                    pss_pkg::STATUS_DONE, 0));
        probes.push_back(make_probe(pss_pkg::MODE_DELETE, 2, 0, 0,
                                    pss_pkg::STATUS_DONE, 0));
        foreach (probes[i]) begin
            offer_request(probes[i].req, probes[i].fixed, probes[i].rsp);
        end

        // Random phases. The first grow phase is long enough to fill the
        // store and hit the full case; later phases swing the count both
        // ways. Drain between phases so the sender pauses on an idle block.
        sent_count = 0;
        phase_idx  = 0;
        while (sent_count < RANDOM_ITEMS) begin
            case (phase_idx % 4)
                0: kind = PH_GROW;
                2: kind = PH_SHRINK;
                default: kind = PH_MIXED;
            endcase
            phase_len   = (phase_idx == 0) ? 140 : $urandom_range(40, 120);
            sender_gaps = ($urandom_range(0, 2) != 0);
            if (phase_idx != 0) begin
                drain_results();
            end
            for (n = 0; n < phase_len && sent_count < RANDOM_ITEMS; n++) begin
                // Drop all idling for the tail of the run.
                if (sent_count >= RANDOM_ITEMS - QUIET_TAIL) begin
                    quiet = 1'b1;
                end
                offer_request(random_request(kind), 1'b0, '0);
            end
            phase_idx++;
        end

        // Wait out the remaining results plus the block's latency.
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
